[hdl/screen_line_diff_packetizer_defines.svh]
// ----------------------------------------------------------------------------
// Screen line difference packetizer: assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCREEN_LINE_DIFF_PACKETIZER_DEFINES_SVH
`define SCREEN_LINE_DIFF_PACKETIZER_DEFINES_SVH

`ifndef SYNTHESIS
// A condition that must hold at every clock edge.
`define SLDP_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// A condition that must hold whenever the antecedent holds.
`define SLDP_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SLDP_CHECK(lbl, expr, msg)
`define SLDP_IMPLY(lbl, ante, cons, msg)
`endif

`endif

[hdl/sldp_pkg.sv]
// ----------------------------------------------------------------------------
// sldp_pkg
// Types and constants shared by the screen line difference packetizer.
// ----------------------------------------------------------------------------
`default_nettype none

package sldp_pkg;

  localparam logic [1:0] FN_WRITE   = 2'd0;
  localparam logic [1:0] FN_CURSOR  = 2'd1;
  localparam logic [1:0] FN_LINE    = 2'd2;
  localparam logic [1:0] FN_REFRESH = 2'd3;

  localparam logic [7:0] HDR_MARK = 8'hFF;
  localparam int         HDR_LEN  = 5;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] row;
    logic [7:0] column;
    logic [7:0] dots;
  } in_item_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       second_valid;
    logic       last_of_packet;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t data;
  } pair_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CURS,
    ST_CHK,
    ST_SCAN,
    ST_PREP,
    ST_BYTE
  } state_t;

endpackage

`default_nettype wire

[hdl/sldp_ram.sv]
// ----------------------------------------------------------------------------
// sldp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sldp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/sldp_outreg.sv]
// ----------------------------------------------------------------------------
// sldp_outreg
// Result holding register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sldp_outreg
  import sldp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire pair_req_t pair,
  output logic           free,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic      valid_r;
  out_item_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pair.valid) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pair.valid) begin
      data_r <= pair.data;
    end
  end

  // The slot can be refilled in the same cycle that the held result leaves.
  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

[hdl/sldp_ctrl.sv]
// ----------------------------------------------------------------------------
// sldp_ctrl
// Sequencer: cell writes, cursor, line and refresh requests, row scan and packet build.
// ----------------------------------------------------------------------------
`default_nettype none

`include "screen_line_diff_packetizer_defines.svh"

module sldp_ctrl
  import sldp_pkg::*;
#(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire logic                                              clk,
  input  wire logic                                              rst_n,
  input  wire logic                                              in_valid,
  output logic                                                   in_ready,
  input  wire in_item_t                                          in_data,
  output logic                                                   w_we,
  output logic [((ROWS*COLS > 1) ? $clog2(ROWS*COLS) : 1)-1:0]   w_addr,
  output logic [7:0]                                             w_wdata,
  output logic                                                   s_we,
  output logic [((ROWS*COLS > 1) ? $clog2(ROWS*COLS) : 1)-1:0]   s_addr,
  output logic [7:0]                                             s_wdata,
  output logic [((ROWS*COLS > 1) ? $clog2(ROWS*COLS) : 1)-1:0]   rd_addr,
  input  wire logic [7:0]                                        w_rdata,
  input  wire logic [7:0]                                        s_rdata,
  output pair_req_t                                              pair,
  input  wire logic                                              out_free
);

  localparam int DEPTH = ROWS * COLS;
  localparam int RA    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AW    = $clog2(DEPTH + 1);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int CW    = $clog2(COLS + 1);
  localparam int JW    = $clog2(COLS + HDR_LEN + 1);

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic            clr_all_r, clr_all_nxt;
  logic            ready_r, ready_nxt;
  logic [RW-1:0]   cur_row_r, cur_row_nxt;
  logic [CW-1:0]   cur_col_r, cur_col_nxt;
  logic [RW-1:0]   sel_r, sel_nxt;
  logic [RW-1:0]   pend_row_r, pend_row_nxt;
  logic [CW-1:0]   pend_col_r, pend_col_nxt;
  logic [RW-1:0]   line_r, line_nxt;
  logic            force_r, force_nxt;
  logic [AW-1:0]   base_r, base_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic            found_r, found_nxt;
  logic [CW-1:0]   first_r, first_nxt;
  logic [CW-1:0]   last_r, last_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   caddr_r, caddr_nxt;
  logic [JW-1:0]   j_r, j_nxt;
  logic            half_r, half_nxt;
  logic [7:0]      hold_r, hold_nxt;

  logic [AW-1:0]   cell_addr;
  logic [AW-1:0]   scan_addr;
  logic [7:0]      row_clamp, col_clamp, line_req;

  assign cell_addr = AW'(in_data.row[RW-1:0]) * AW'(COLS) + AW'(in_data.column[CW-1:0]);
  assign scan_addr = base_r + AW'(k_r);
  assign line_req  = in_data.row - 8'd1;

  always_comb begin
    if (in_data.row == 8'd0) begin
      row_clamp = 8'd0;
    end else if (in_data.row > 8'(ROWS)) begin
      row_clamp = 8'(ROWS - 1);
    end else begin
      row_clamp = in_data.row - 8'd1;
    end
    if (in_data.column == 8'd0) begin
      col_clamp = 8'd0;
    end else if (in_data.column > 8'(COLS)) begin
      col_clamp = 8'(COLS - 1);
    end else begin
      col_clamp = in_data.column - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      clr_all_r <= 1'b1;
      ready_r   <= 1'b0;
      cur_row_r <= RW'(ROWS);
      cur_col_r <= CW'(COLS);
      sel_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      clr_all_r <= clr_all_nxt;
      ready_r   <= ready_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      sel_r     <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_row_r <= pend_row_nxt;
    pend_col_r <= pend_col_nxt;
    line_r     <= line_nxt;
    force_r    <= force_nxt;
    base_r     <= base_nxt;
    k_r        <= k_nxt;
    found_r    <= found_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    cnt_r      <= cnt_nxt;
    caddr_r    <= caddr_nxt;
    j_r        <= j_nxt;
    half_r     <= half_nxt;
    hold_r     <= hold_nxt;
  end

  always_comb begin
    logic [CW-1:0] idx;
    logic [CW-1:0] count;
    logic          is_cell;
    logic          is_last;
    logic          consume;
    logic [7:0]    byte_v;
    logic [JW-1:0] last_j;

    state_nxt    = state_r;
    clr_nxt      = clr_r;
    clr_all_nxt  = clr_all_r;
    ready_nxt    = ready_r;
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    sel_nxt      = sel_r;
    pend_row_nxt = pend_row_r;
    pend_col_nxt = pend_col_r;
    line_nxt     = line_r;
    force_nxt    = force_r;
    base_nxt     = base_r;
    k_nxt        = k_r;
    found_nxt    = found_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    cnt_nxt      = cnt_r;
    caddr_nxt    = caddr_r;
    j_nxt        = j_r;
    half_nxt     = half_r;
    hold_nxt     = hold_r;

    in_ready = 1'b0;
    w_we     = 1'b0;
    w_addr   = clr_r[RA-1:0];
    w_wdata  = 8'd0;
    s_we     = 1'b0;
    s_addr   = clr_r[RA-1:0];
    s_wdata  = 8'd0;
    rd_addr  = caddr_r[RA-1:0];
    pair     = '0;

    idx     = k_r - CW'(1);
    count   = found_r ? (last_r - first_r + CW'(1)) : '0;
    is_cell = (j_r >= JW'(HDR_LEN));
    last_j  = JW'(cnt_r) + JW'(HDR_LEN - 1);
    is_last = (j_r == last_j);
    consume = 1'b0;
    byte_v  = w_rdata;

    unique case (state_r)
      ST_CLEAR: begin
        w_we = clr_all_r;
        s_we = 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          clr_nxt   = '0;
          state_nxt = clr_all_r ? ST_IDLE : ST_CURS;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_data.func)
            FN_WRITE: begin
              if (in_data.row < 8'(ROWS) && in_data.column < 8'(COLS)) begin
                w_we    = 1'b1;
                w_addr  = cell_addr[RA-1:0];
                w_wdata = in_data.dots;
              end
            end
            FN_CURSOR: begin
              pend_row_nxt = row_clamp[RW-1:0];
              pend_col_nxt = col_clamp[CW-1:0];
              if (!ready_r) begin
                // First cursor report: shadow starts over from blank.
                ready_nxt   = 1'b1;
                sel_nxt     = row_clamp[RW-1:0];
                cur_row_nxt = RW'(ROWS);
                cur_col_nxt = CW'(COLS);
                clr_nxt     = '0;
                clr_all_nxt = 1'b0;
                state_nxt   = ST_CLEAR;
              end else begin
                state_nxt = ST_CURS;
              end
            end
            FN_LINE: begin
              if (in_data.row == 8'd0) begin
                line_nxt  = cur_row_r;
                force_nxt = 1'b1;
                state_nxt = ST_CHK;
              end else if (in_data.row <= 8'(ROWS)) begin
                sel_nxt   = line_req[RW-1:0];
                line_nxt  = line_req[RW-1:0];
                force_nxt = 1'b0;
                state_nxt = ST_CHK;
              end
            end
            FN_REFRESH: begin
              if (ready_r) begin
                line_nxt  = sel_r;
                force_nxt = 1'b0;
                state_nxt = ST_CHK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_CURS: begin
        if (pend_row_r != cur_row_r || pend_col_r != cur_col_r) begin
          cur_row_nxt = pend_row_r;
          cur_col_nxt = pend_col_r;
          line_nxt    = pend_row_r;
          force_nxt   = 1'b1;
          state_nxt   = ST_CHK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_CHK: begin
        // A cursor row still at its reset value names no line.
        if (line_r >= RW'(ROWS)) begin
          state_nxt = ST_IDLE;
        end else begin
          base_nxt  = AW'(line_r) * AW'(COLS);
          k_nxt     = '0;
          found_nxt = 1'b0;
          first_nxt = '0;
          last_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        rd_addr = scan_addr[RA-1:0];
        // Read data is registered, so the data here belongs to the previous address, cell k-1.
        if (k_r != '0 && w_rdata != s_rdata) begin
          if (!found_r) begin
            first_nxt = idx;
          end
          last_nxt  = idx;
          found_nxt = 1'b1;
        end
        if (k_r == CW'(COLS)) begin
          state_nxt = ST_PREP;
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end

      ST_PREP: begin
        if (!found_r && !force_r) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt   = count;
          caddr_nxt = base_r + AW'(first_r);
          j_nxt     = '0;
          half_nxt  = 1'b0;
          state_nxt = ST_BYTE;
        end
      end

      ST_BYTE: begin
        if (j_r == JW'(0)) begin
          byte_v = HDR_MARK;
        end else if (j_r == JW'(1)) begin
          byte_v = 8'(line_r) + 8'd1;
        end else if (j_r == JW'(2)) begin
          byte_v = (line_r == cur_row_r) ? (8'(cur_col_r) + 8'd1) : 8'd0;
        end else if (j_r == JW'(3)) begin
          byte_v = 8'(first_r) + 8'd1;
        end else if (j_r == JW'(4)) begin
          byte_v = 8'(cnt_r);
        end
        if (!half_r && !is_last) begin
          hold_nxt = byte_v;
          half_nxt = 1'b1;
          consume  = 1'b1;
        end else if (out_free) begin
          pair.valid               = 1'b1;
          pair.data.first_byte     = half_r ? hold_r : byte_v;
          pair.data.second_byte    = half_r ? byte_v : 8'd0;
          pair.data.second_valid   = half_r;
          pair.data.last_of_packet = is_last;
          half_nxt                 = 1'b0;
          consume                  = 1'b1;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
        if (consume) begin
          j_nxt = j_r + JW'(1);
          if (is_cell) begin
            // The byte sent is the wanted cell, which now becomes the shadow.
            s_we      = 1'b1;
            s_addr    = caddr_r[RA-1:0];
            s_wdata   = w_rdata;
            caddr_nxt = caddr_r + AW'(1);
            rd_addr   = caddr_nxt[RA-1:0];
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `SLDP_IMPLY(a_wanted_write_idle, w_we, state_r == ST_CLEAR || state_r == ST_IDLE, "wanted image written outside clear or idle")
  `SLDP_IMPLY(a_shadow_copy_cell, s_we && state_r == ST_BYTE, j_r >= JW'(HDR_LEN), "shadow written on a header byte")
  `SLDP_IMPLY(a_pair_phase, state_r == ST_BYTE, half_r == j_r[0], "byte pairing out of step with byte index")
  `SLDP_IMPLY(a_no_overrun, pair.valid, out_free, "result loaded into a full output register")
  `SLDP_CHECK(a_cursor_range, cur_row_r <= RW'(ROWS) && cur_col_r <= CW'(COLS), "cursor register out of range")

endmodule

`default_nettype wire

[hdl/screen_line_diff_packetizer.sv]
// ----------------------------------------------------------------------------
// screen_line_diff_packetizer
// Keeps a wanted and a sent cell image and emits row update packets.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Moves
//  input     in_valid / in_ready / in_data   one request (in_item_t)
//  result    out_valid / out_ready / out_data  one or two packet bytes (out_item_t)
//
//  After reset both images are cleared before in_ready rises.
//  A row send scans the row with one read per cell on the RAM read port,
//  then emits one packet byte per cycle while the result channel allows.
//  The first cursor request clears the shadow first.
//  A stalled result channel holds the byte sequencer; one result waits in the
//  output register.
// ----------------------------------------------------------------------------
`default_nettype none

module screen_line_diff_packetizer
  import sldp_pkg::*;
#(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  localparam int DEPTH = ROWS * COLS;
  localparam int RA    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          w_we, s_we;
  logic [RA-1:0] w_addr, s_addr, rd_addr;
  logic [7:0]    w_wdata, s_wdata, w_rdata, s_rdata;
  pair_req_t     pair;
  logic          out_free;

  sldp_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_wanted (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_addr),
    .wdata (w_wdata),
    .raddr (rd_addr),
    .rdata (w_rdata)
  );

  sldp_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_sent (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_addr),
    .wdata (s_wdata),
    .raddr (rd_addr),
    .rdata (s_rdata)
  );

  sldp_ctrl #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .w_we     (w_we),
    .w_addr   (w_addr),
    .w_wdata  (w_wdata),
    .s_we     (s_we),
    .s_addr   (s_addr),
    .s_wdata  (s_wdata),
    .rd_addr  (rd_addr),
    .w_rdata  (w_rdata),
    .s_rdata  (s_rdata),
    .pair     (pair),
    .out_free (out_free)
  );

  sldp_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .pair      (pair),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[tb/tb_screen_line_diff_packetizer.sv]
// ----------------------------------------------------------------------------
// tb_screen_line_diff_packetizer
// Sends cell writes, cursor moves, line requests and refreshes to the
// packetizer, first from a directed table, then at random. Each byte pair is
// checked against the table or a behavioral copy of the wanted and shadow images.
// ----------------------------------------------------------------------------
module tb_screen_line_diff_packetizer;
  timeunit 1ns;
  timeprecision 1ps;

  import sldp_pkg::*;

  localparam int ROWS         = 25;
  localparam int COLS         = 80;
  localparam int RANDOM_ITEMS = 95;
  localparam int QUIET_ITEMS  = 20;
  localparam int TAIL_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 400000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  screen_line_diff_packetizer #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Behavioral screen state.
  logic [7:0]  want_img [ROWS*COLS];
  logic [7:0]  sent_img [ROWS*COLS];
  int unsigned cur_row;
  int unsigned cur_col;
  int unsigned sel_line;
  bit          screen_live;

  out_item_t line_pairs[$];
  out_item_t expected_pairs[$];
  int        item_tags[$];

  // Directed table: a count of -1 means the row is checked against the model.
  in_item_t  dir_items[$];
  int        dir_count[$];
  out_item_t dir_pairs[$];

  int errors         = 0;
  int accepted_items = 0;
  int offered_items  = 0;
  int cycles         = 0;
  bit quiet_tail     = 1'b0;

  function automatic out_item_t pair_of(logic [7:0] a, logic [7:0] b, logic v, logic l);
    return {a, b, v, l};
  endfunction

  function automatic int unsigned clamp_pos(int unsigned v, int unsigned hi);
    if (v < 1) v = 1;
    if (v > hi) v = hi;
    return v - 1;
  endfunction

  // Finds the differing span of a line, syncs the shadow and packs the packet.
  function automatic void send_line(int unsigned line, bit forced);
    logic [7:0]  pkt[$];
    int unsigned base;
    int unsigned stop;
    int unsigned first;
    int unsigned cnt;
    if (line >= ROWS) return;
    base = line * COLS;
    stop = COLS;
    while (stop > 0 && want_img[base + stop - 1] == sent_img[base + stop - 1]) stop--;
    first = 0;
    while (first < stop && want_img[base + first] == sent_img[base + first]) first++;
    cnt = stop - first;
    if (cnt == 0 && !forced) return;
    pkt.push_back(HDR_MARK);
    pkt.push_back(8'(line + 1));
    pkt.push_back((line == cur_row) ? 8'(cur_col + 1) : 8'h00);
    pkt.push_back(8'(first + 1));
    pkt.push_back(8'(cnt));
    for (int unsigned i = first; i < stop; i++) begin
      sent_img[base + i] = want_img[base + i];
      pkt.push_back(want_img[base + i]);
    end
    for (int k = 0; k < pkt.size(); k += 2) begin
      line_pairs.push_back(pair_of(pkt[k], (k + 1 < pkt.size()) ? pkt[k + 1] : 8'h00,
                                   k + 1 < pkt.size(), k + 2 >= pkt.size()));
    end
  endfunction

  function automatic void screen_update(in_item_t it);
    int unsigned r;
    int unsigned c;
    line_pairs.delete();
    case (it.func)
      FN_WRITE: begin
        if (it.row < ROWS && it.column < COLS) want_img[it.row * COLS + it.column] = it.dots;
      end
      FN_CURSOR: begin
        r = clamp_pos(it.row, ROWS);
        c = clamp_pos(it.column, COLS);
        // The first cursor request brings the screen up with a blank shadow.
        if (!screen_live) begin
          foreach (sent_img[i]) sent_img[i] = 8'h00;
          sel_line    = r;
          cur_row     = ROWS;
          cur_col     = COLS;
          screen_live = 1'b1;
        end
        if (r != cur_row || c != cur_col) begin
          cur_row = r;
          cur_col = c;
          send_line(cur_row, 1'b1);
        end
      end
      FN_LINE: begin
        if (it.row == 0) begin
          send_line(cur_row, 1'b1);
        end else if (it.row <= ROWS) begin
          sel_line = it.row - 1;
          send_line(sel_line, 1'b0);
        end
      end
      FN_REFRESH: begin
        if (screen_live) send_line(sel_line, 1'b0);
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic void add_row(logic [1:0] f, logic [7:0] r, logic [7:0] c,
                                  logic [7:0] d, int n, out_item_t p0 = '0,
                                  out_item_t p1 = '0, out_item_t p2 = '0);
    dir_items.push_back({f, r, c, d});
    dir_count.push_back(n);
    dir_pairs.push_back(p0);
    dir_pairs.push_back(p1);
    dir_pairs.push_back(p2);
  endfunction

  task automatic offer(input in_item_t it, input int tag);
    item_tags.push_back(tag);
    offered_items++;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (accepted_items < offered_items || expected_pairs.size() != 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Request and result monitor: predicts on each accepted request and checks
  // each accepted result in the same block.
  always @(posedge clk) begin
    int        tag;
    out_item_t want;
    if (rst_n && in_valid && in_ready) begin
      tag = item_tags.pop_front();
      screen_update(in_data);
      if (tag >= 0 && dir_count[tag] >= 0) begin
        for (int k = 0; k < dir_count[tag]; k++) expected_pairs.push_back(dir_pairs[3*tag + k]);
      end else begin
        foreach (line_pairs[k]) expected_pairs.push_back(line_pairs[k]);
      end
      accepted_items++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        want = expected_pairs.pop_front();
        check_field("first_byte", want.first_byte, out_data.first_byte);
        check_field("second_byte", want.second_byte, out_data.second_byte);
        check_field("second_valid", 8'(want.second_valid), 8'(out_data.second_valid));
        check_field("last_of_packet", 8'(want.last_of_packet), 8'(out_data.last_of_packet));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side back-pressure.
  initial begin
    out_ready <= 1'b1;
    @(posedge clk);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 32)) @(posedge clk);
    end
  end

  initial begin
    in_item_t it;
    int       pick;
    int       counted;
    bit       ignored;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    foreach (want_img[i]) begin
      want_img[i] = 8'h00;
      sent_img[i] = 8'h00;
    end
    cur_row     = ROWS;
    cur_col     = COLS;
    sel_line    = 0;
    screen_live = 1'b0;

    // Before the first cursor request these requests send nothing.
    add_row(FN_REFRESH, 8'd0, 8'd0, 8'd0, 0);
    add_row(FN_LINE, 8'd0, 8'd0, 8'd0, 0);
    add_row(FN_LINE, 8'(ROWS + 1), 8'd0, 8'd0, 0);
    add_row(FN_LINE, 8'hFF, 8'hFF, 8'hFF, 0);
    add_row(FN_LINE, 8'd1, 8'd0, 8'd0, 0);
    add_row(FN_WRITE, 8'd0, 8'd0, 8'hFF, 0);
    add_row(FN_WRITE, 8'(ROWS - 1), 8'(COLS - 1), 8'h81, 0);
    // Out of range cell writes are dropped.
    add_row(FN_WRITE, 8'(ROWS), 8'd0, 8'h55, 0);
    add_row(FN_WRITE, 8'd0, 8'(COLS), 8'hAA, 0);
    add_row(FN_WRITE, 8'hFF, 8'hFF, 8'h00, 0);
    add_row(FN_CURSOR, 8'd0, 8'd0, 8'd0, 3, pair_of(HDR_MARK, 8'h01, 1'b1, 1'b0),
            pair_of(8'h01, 8'h01, 1'b1, 1'b0), pair_of(8'h01, 8'hFF, 1'b1, 1'b1));
    add_row(FN_CURSOR, 8'd1, 8'd1, 8'd0, 0);
    add_row(FN_REFRESH, 8'd0, 8'd0, 8'd0, 0);
    add_row(FN_LINE, 8'd0, 8'd0, 8'd0, 3, pair_of(HDR_MARK, 8'h01, 1'b1, 1'b0),
            pair_of(8'h01, 8'h01, 1'b1, 1'b0), pair_of(8'h00, 8'h00, 1'b0, 1'b1));
    add_row(FN_CURSOR, 8'hFF, 8'hFF, 8'd0, 3, pair_of(HDR_MARK, 8'(ROWS), 1'b1, 1'b0),
            pair_of(8'(COLS), 8'(COLS), 1'b1, 1'b0), pair_of(8'h01, 8'h81, 1'b1, 1'b1));
    add_row(FN_LINE, 8'(ROWS), 8'd0, 8'd0, 0);
    add_row(FN_WRITE, 8'(ROWS - 1), 8'd0, 8'h01, 0);
    add_row(FN_WRITE, 8'(ROWS - 1), 8'(COLS - 1), 8'h00, 0);
    add_row(FN_REFRESH, 8'd0, 8'd0, 8'd0, -1);
    add_row(FN_LINE, 8'd0, 8'd0, 8'd0, 3, pair_of(HDR_MARK, 8'(ROWS), 1'b1, 1'b0),
            pair_of(8'(COLS), 8'h01, 1'b1, 1'b0), pair_of(8'h00, 8'h00, 1'b0, 1'b1));
    add_row(FN_WRITE, 8'd1, 8'd5, 8'hAA, 0);
    add_row(FN_WRITE, 8'd1, 8'd9, 8'h55, 0);
    add_row(FN_LINE, 8'd2, 8'd0, 8'd0, -1);
    add_row(FN_CURSOR, 8'd2, 8'd0, 8'd0, 3, pair_of(HDR_MARK, 8'h02, 1'b1, 1'b0),
            pair_of(8'h01, 8'h01, 1'b1, 1'b0), pair_of(8'h00, 8'h00, 1'b0, 1'b1));
    add_row(FN_CURSOR, 8'(ROWS), 8'(COLS), 8'd0, -1);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < dir_items.size(); n++) begin
      offer(dir_items[n], n);
      if ($urandom_range(0, 2) == 0) pause_input($urandom_range(1, 16));
    end
    // Hold off until every packet of the directed part has come back.
    in_valid <= 1'b0;
    drain();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      quiet_tail = (counted >= RANDOM_ITEMS - QUIET_ITEMS);
      pick      = $urandom_range(0, 99);
      it.dots   = 8'($urandom_range(0, 255));
      it.row    = 8'($urandom_range(0, 255));
      it.column = 8'($urandom_range(0, 255));
      if (pick < 50) begin
        it.func = FN_WRITE;
        // Most writes land on a few lines so that refreshes find real spans.
        if ($urandom_range(0, 9) != 0) begin
          it.row    = ($urandom_range(0, 4) < 3) ? 8'($urandom_range(0, 3))
                                                 : 8'($urandom_range(0, ROWS - 1));
          it.column = 8'($urandom_range(0, COLS - 1));
        end
      end else if (pick < 65) begin
        it.func = FN_CURSOR;
        if ($urandom_range(0, 4) != 0) begin
          it.row    = 8'($urandom_range(1, ROWS));
          it.column = 8'($urandom_range(1, COLS));
        end
      end else if (pick < 85) begin
        it.func = FN_LINE;
        case ($urandom_range(0, 5))
          0, 1: it.row = 8'h00;
          2, 3: it.row = 8'($urandom_range(1, 4));
          4: it.row = 8'($urandom_range(1, ROWS));
          default: ;
        endcase
      end else begin
        it.func = FN_REFRESH;
      end
      ignored = (it.func == FN_WRITE && (it.row >= ROWS || it.column >= COLS)) ||
                (it.func == FN_LINE && it.row > ROWS);
      offer(it, -1);
      if (!ignored) counted++;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        pause_input($urandom_range(1, 16));
      end else if (!quiet_tail && $urandom_range(0, 24) == 0) begin
        in_valid <= 1'b0;
        drain();
      end
    end
    in_valid <= 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && expected_pairs.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
